[design/itemset_utility_accumulator_assert.svh]
// Assertion macros shared by the itemset utility accumulator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ITEMSET_UTILITY_ACCUMULATOR_ASSERT_SVH
`define ITEMSET_UTILITY_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define IUA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IUA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/iua_pkg.sv]
// Package for the itemset utility accumulator: sizes, opcodes, beat types.
// No dependencies; imported by every module of the block.
`default_nettype none

package iua_pkg;

    localparam int NUM_ITEMS  = 4096;
    localparam int TOTAL_BITS = 48;

    localparam int ID_W    = 12;
    localparam int UTIL_W  = 16;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 32;
    localparam int ADDR_W  = $clog2(NUM_ITEMS);
    localparam int SET_W   = $clog2(NUM_ITEMS + 1);
    // one spare bit so a saturated match count can never equal the set size
    localparam int MATCH_W = SET_W + 1;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_ELEMENT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ID_W-1:0]   item_id;
        logic [UTIL_W-1:0] utility;
        logic              member;
        logic              last_element;
    } iua_item_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] util_accum;
        logic                  transaction_done;
        logic                  contained;
        logic [CNT_W-1:0]      transaction_index;
        logic [CNT_W-1:0]      containing_count;
    } iua_result_t;

    // bitmap write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              member;
    } iua_wr_t;

    // one item with its bitmap lookup, handed to the accumulator
    typedef struct packed {
        logic [1:0]        opcode;
        logic              in_range;
        logic              old_member;
        logic              member;
        logic [UTIL_W-1:0] utility;
        logic              last_element;
    } iua_step_t;

    function automatic logic iua_in_range(input logic [ID_W-1:0] id);
        return 32'(id) < 32'(NUM_ITEMS);
    endfunction

endpackage

`default_nettype wire

[design/iua_bitmap_mem.sv]
// Membership bitmap: one-bit synchronous RAM with registered read data
// and a clearing sweep after reset. Depends on iua_pkg.
`default_nettype none

module iua_bitmap_mem
    import iua_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic                   rd_data,
    input  wire iua_wr_t           wr,
    output logic                   busy
);

    logic                mem [NUM_ITEMS];
    logic                rd_data_reg;
    logic                clr_active_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == ADDR_W'(NUM_ITEMS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.member;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

`default_nettype wire

[design/iua_accum.sv]
// Accumulator: set size, per-transaction sums, saturating totals and the
// result output register. Depends on iua_pkg and the assertion macros.
`default_nettype none

`include "itemset_utility_accumulator_assert.svh"

module iua_accum
    import iua_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_valid,
    output logic             step_ready,
    input  wire iua_step_t   step,
    output logic             result_valid,
    input  wire logic        result_ready,
    output iua_result_t      result
);

    localparam int ACC_W = ((TOTAL_BITS > SUM_W) ? TOTAL_BITS : SUM_W) + 1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    logic [SET_W-1:0]      set_size_reg,  set_size_next;
    logic [MATCH_W-1:0]    match_reg,     match_next;
    logic [SUM_W-1:0]      sum_reg,       sum_next;
    logic [TOTAL_BITS-1:0] total_reg,     total_next;
    logic [CNT_W-1:0]      tx_cnt_reg,    tx_cnt_next;
    logic [CNT_W-1:0]      contain_reg,   contain_next;
    logic                  result_valid_reg;
    iua_result_t           result_reg,    result_next;

    logic                  step_fire;
    logic                  hit;
    logic                  done;
    logic                  cont;
    logic [SUM_W:0]        sum_add;
    logic [SUM_W-1:0]      sum_after;
    logic [MATCH_W-1:0]    match_after;
    logic [ACC_W-1:0]      total_add;
    logic [CNT_W-1:0]      tx_index;

    assign step_ready = !result_valid_reg || result_ready;
    assign step_fire  = step_valid && step_ready;

    always_comb
    begin
        hit  = (step.opcode == OP_ELEMENT) && step.in_range && step.old_member;
        done = (step.opcode == OP_ELEMENT) && step.last_element;

        sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(step.utility);
        sum_after = sum_reg;
        if (hit)
        begin
            sum_after = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        end

        match_after = match_reg;
        if (hit && (match_reg != '1))
        begin
            match_after = match_reg + 1'b1;
        end

        cont = done && (match_after == MATCH_W'(set_size_reg));

        set_size_next = set_size_reg;
        if ((step.opcode == OP_WRITE) && step.in_range)
        begin
            if (!step.old_member && step.member)
            begin
                set_size_next = set_size_reg + 1'b1;
            end
            else if (step.old_member && !step.member)
            begin
                set_size_next = set_size_reg - 1'b1;
            end
        end

        total_add    = ACC_W'(total_reg) + ACC_W'(sum_after);
        total_next   = total_reg;
        contain_next = contain_reg;
        tx_cnt_next  = tx_cnt_reg;
        sum_next     = sum_after;
        match_next   = match_after;

        if (step.opcode == OP_CLEAR)
        begin
            total_next   = '0;
            contain_next = '0;
            tx_cnt_next  = '0;
            sum_next     = '0;
            match_next   = '0;
        end
        else if (cont)
        begin
            total_next = (total_add > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                         : total_add[TOTAL_BITS-1:0];
            if (contain_reg != '1)
            begin
                contain_next = contain_reg + 1'b1;
            end
        end

        tx_index = tx_cnt_next;
        if (done)
        begin
            tx_cnt_next = tx_cnt_next + 1'b1;
            sum_next    = '0;
            match_next  = '0;
        end

        result_next.util_accum        = total_next;
        result_next.transaction_done  = done;
        result_next.contained         = cont;
        result_next.transaction_index = tx_index;
        result_next.containing_count  = contain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg     <= '0;
            match_reg        <= '0;
            sum_reg          <= '0;
            total_reg        <= '0;
            tx_cnt_reg       <= '0;
            contain_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_fire)
            begin
                set_size_reg <= set_size_next;
                match_reg    <= match_next;
                sum_reg      <= sum_next;
                total_reg    <= total_next;
                tx_cnt_reg   <= tx_cnt_next;
                contain_reg  <= contain_next;
            end
            if (step_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `IUA_ASSERT_IMP(a_contained_on_end, result_valid_reg,
        !result_reg.contained || result_reg.transaction_done,
        "contained flagged on a beat that ended no transaction")
    `IUA_ASSERT_IMP(a_set_size_bound, 1'b1,
        32'(set_size_reg) <= 32'(NUM_ITEMS),
        "set size exceeds the number of items")
    `IUA_ASSERT_NXT(a_clear_zeroes, step_fire && (step.opcode == OP_CLEAR),
        (result_reg.util_accum == '0) && (result_reg.containing_count == '0),
        "clear did not zero the totals")

endmodule

`default_nettype wire

[design/itemset_utility_accumulator.sv]
// Top level of the itemset utility accumulator: input stage, bitmap RAM
// with write forwarding, accumulator. Depends on iua_pkg, iua_bitmap_mem,
// iua_accum and the assertion macros.
//
//  channel | direction | handshake                  | beat type
//  item    | in        | item_valid / item_ready     | iua_item_t
//  result  | out       | result_valid / result_ready | iua_result_t
//
// One item per cycle sustained while result_ready stays high; each item's result
// is registered in order: bitmap read on the accepting edge, then accumulate
// into the output register once the accumulate stage can move on.
// After reset the bitmap is swept to zero, one entry per cycle: item_ready
// stays low until all NUM_ITEMS (4096) entries are cleared.
// A result that waits on result_ready holds the accumulate stage; the input
// stage keeps taking a beat as long as that stage can move on.
`default_nettype none

`include "itemset_utility_accumulator_assert.svh"

module itemset_utility_accumulator
    import iua_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire iua_item_t   item,
    output logic             result_valid,
    input  wire logic        result_ready,
    output iua_result_t      result
);

    logic        s1_valid_reg;
    iua_item_t   s1_item_reg;
    logic        fwd_hit_reg;
    logic        fwd_bit_reg;

    logic        s1_ready;
    logic        s1_fire;
    logic        item_fire;
    logic        mem_busy;
    logic        rd_data;
    logic        s1_in_range;
    iua_wr_t     wr;
    iua_step_t   step;

    assign item_ready  = !mem_busy && (!s1_valid_reg || s1_ready);
    assign item_fire   = item_valid && item_ready;
    assign s1_fire     = s1_valid_reg && s1_ready;
    assign s1_in_range = iua_in_range(s1_item_reg.item_id);

    always_comb
    begin
        wr.en     = s1_fire && (s1_item_reg.opcode == OP_WRITE) && s1_in_range;
        wr.addr   = ADDR_W'(s1_item_reg.item_id);
        wr.member = s1_item_reg.member;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // catch a write landing on the same edge as this beat's read
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_item_reg <= item;
            fwd_hit_reg <= wr.en && (wr.addr == ADDR_W'(item.item_id));
            fwd_bit_reg <= wr.member;
        end
    end

    iua_bitmap_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (item_fire),
        .rd_addr (ADDR_W'(item.item_id)),
        .rd_data (rd_data),
        .wr      (wr),
        .busy    (mem_busy)
    );

    always_comb
    begin
        step.opcode       = s1_item_reg.opcode;
        step.in_range     = s1_in_range;
        step.old_member   = fwd_hit_reg ? fwd_bit_reg : rd_data;
        step.member       = s1_item_reg.member;
        step.utility      = s1_item_reg.utility;
        step.last_element = s1_item_reg.last_element;
    end

    iua_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (s1_valid_reg),
        .step_ready   (s1_ready),
        .step         (step),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `IUA_ASSERT_IMP(a_no_take_in_sweep, mem_busy, !item_ready,
        "item taken during the bitmap clearing sweep")
    `IUA_ASSERT_NXT(a_fwd_only_on_write, item_fire && !wr.en, !fwd_hit_reg,
        "forwarding flagged without a bitmap write")

endmodule

`default_nettype wire
